// File: rtl/core/mrta_pkg.sv
// Shared types and constants for the memory region table allocator.
`timescale 1ns / 1ps

package mrta_pkg;

  // One table entry is packed as {base, size, type}.
  localparam int ENTRY_W = 132;

  localparam logic [63:0] GRAN_4K   = 64'h0000_0000_0000_1000;
  localparam logic [63:0] GRAN_2M   = 64'h0000_0000_0020_0000;
  localparam logic [63:0] SIZE_MASK = 64'hFFFF_FFFF_FFFF_FFF0;
  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  // Request kinds.
  localparam logic [2:0] KIND_LOAD     = 3'd0;
  localparam logic [2:0] KIND_ALIGN    = 3'd1;
  localparam logic [2:0] KIND_ALLOC_4K = 3'd2;
  localparam logic [2:0] KIND_ALLOC_2M = 3'd3;

  // Region types with a meaning to the allocator.
  localparam logic [3:0] TYPE_USED = 4'd0;
  localparam logic [3:0] TYPE_FREE = 4'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_ALIGN,
    S_FIND,
    S_PLACE,
    S_SHIFT,
    S_WPAD,
    S_WUSED,
    S_WREST,
    S_SUM_INIT,
    S_SUM,
    S_DONE
  } state_t;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_PREP,
    DP_LOAD,
    DP_ALIGN,
    DP_FIND,
    DP_PLACE,
    DP_SHIFT,
    DP_WPAD,
    DP_WUSED,
    DP_WREST,
    DP_SUM_INIT,
    DP_SUM
  } dp_op_t;

  // Status returned by the datapath to the controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       alloc_skip;
    logic       scan_done;
    logic       find_done;
    logic       place_go;
    logic       has_pad;
    logic       shift_done;
  } dp_stat_t;

endpackage

// File: rtl/core/mrta_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mrta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/mrta_ctrl.sv
// Controller state machine that sequences the allocator datapath.
`timescale 1ns / 1ps

module mrta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mrta_pkg::dp_stat_t stat,
  output mrta_pkg::dp_op_t  op,
  output logic              busy,
  output logic              out_valid
);

  import mrta_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    op        = DP_NONE;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op        = DP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        op = DP_PREP;
        unique case (stat.kind) inside
          KIND_LOAD:                    state_nxt = S_LOAD;
          KIND_ALIGN:                   state_nxt = S_ALIGN;
          KIND_ALLOC_4K, KIND_ALLOC_2M: state_nxt = stat.alloc_skip ? S_SUM_INIT : S_FIND;
          default:                      state_nxt = S_SUM_INIT;
        endcase
      end
      S_LOAD: begin
        op        = DP_LOAD;
        state_nxt = S_SUM_INIT;
      end
      S_ALIGN: begin
        op = DP_ALIGN;
        if (stat.scan_done) begin
          state_nxt = S_SUM_INIT;
        end
      end
      S_FIND: begin
        op = DP_FIND;
        if (stat.find_done) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        op        = DP_PLACE;
        state_nxt = stat.place_go ? S_SHIFT : S_SUM_INIT;
      end
      S_SHIFT: begin
        op = DP_SHIFT;
        if (stat.shift_done) begin
          state_nxt = stat.has_pad ? S_WPAD : S_WUSED;
        end
      end
      S_WPAD: begin
        op        = DP_WPAD;
        state_nxt = S_WUSED;
      end
      S_WUSED: begin
        op        = DP_WUSED;
        state_nxt = S_WREST;
      end
      S_WREST: begin
        op        = DP_WREST;
        state_nxt = S_SUM_INIT;
      end
      S_SUM_INIT: begin
        op        = DP_SUM_INIT;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        op = DP_SUM;
        if (stat.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/mrta_dp.sv
// Datapath of the allocator: region table memory, sweep pointer and arithmetic.
`timescale 1ns / 1ps

module mrta_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mrta_pkg::dp_op_t   op,
  output mrta_pkg::dp_stat_t stat,
  input  logic [2:0]         in_kind,
  input  logic [63:0]        in_region_base,
  input  logic [63:0]        in_region_size,
  input  logic [3:0]         in_region_type,
  input  logic               in_first_of_map,
  input  logic [63:0]        in_request_bytes,
  output logic [63:0]        out_alloc_address,
  output logic [1:0]         out_status,
  output logic [6:0]         out_entry_count,
  output logic [63:0]        out_highest_free_top,
  output logic [63:0]        out_total_free
);

  import mrta_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Moves a base up to a 4 KiB boundary and trims the size to whole granules.
  function automatic logic [ENTRY_W-1:0] align_entry(input logic [ENTRY_W-1:0] e);
    logic [63:0] b;
    logic [63:0] s;
    logic [63:0] d;
    b = e[131:68];
    s = e[67:4];
    d = GRAN_4K - {52'd0, b[11:0]};
    if (b[11:0] != 12'd0) begin
      b = b + d;
      s = (s >= d) ? s - d : 64'd0;
    end
    s = s & ~(GRAN_4K - 64'd1);
    return {b, s, e[3:0]};
  endfunction

  // Captured request.
  logic [2:0]  kind_r, kind_nxt;
  logic [63:0] base_in_r, base_in_nxt;
  logic [63:0] size_in_r, size_in_nxt;
  logic [3:0]  type_in_r, type_in_nxt;
  logic        first_r, first_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic        rfail_r, rfail_nxt;
  logic [63:0] need_r, need_nxt;

  // Table and sweep control.
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [63:0]   fb_r, fb_nxt;
  logic [63:0]   fs_r, fs_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [63:0]   cur_r, cur_nxt;
  logic [63:0]   rem_r, rem_nxt;

  // Result registers.
  logic [63:0] addr_r, addr_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [63:0] top_r, top_nxt;
  logic [63:0] total_r, total_nxt;

  // Memory port.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] rd_data;

  // Helper values.
  logic [63:0]   gran_m1;
  logic [64:0]   rnd_sum;
  logic [64:0]   need_sum;
  logic          fail_c;
  logic [63:0]   rd_base;
  logic [63:0]   rd_size;
  logic [3:0]    rd_type;
  logic [20:0]   brem;
  logic [63:0]   pad_c;
  logic          has_pad;
  logic [1:0]    d_c;
  logic          room;
  logic [CW-1:0] pos_c;
  logic [64:0]   top_sum;
  logic [63:0]   top_c;
  logic [64:0]   tot_sum;

  mrta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign rd_base = rd_data[131:68];
  assign rd_size = rd_data[67:4];
  assign rd_type = rd_data[3:0];

  // Request rounding to the granule of its kind; bit 64 flags overflow.
  assign gran_m1  = ((in_kind == KIND_ALLOC_2M) ? GRAN_2M : GRAN_4K) - 64'd1;
  assign rnd_sum  = {1'b0, in_request_bytes} + {1'b0, gran_m1};
  assign need_sum = {1'b0, bytes_r} + {1'b0, GRAN_2M};
  assign fail_c   = rfail_r || ((kind_r == KIND_ALLOC_2M) && need_sum[64]);

  // Pad that brings the fitting region up to a 2 MiB boundary.
  assign brem    = fb_r[20:0];
  assign pad_c   = (brem != 21'd0) ? GRAN_2M - {43'd0, brem} : 64'd0;
  assign has_pad = (kind_r == KIND_ALLOC_2M) && (brem != 21'd0);
  assign d_c     = has_pad ? 2'd2 : 2'd1;
  assign room    = ({1'b0, count_r} + (CW+1)'(d_c)) <= (CW+1)'(TABLE_DEPTH);
  assign pos_c   = first_r ? '0 : count_r;

  // Saturating free top and free total for the summary sweep.
  assign top_sum = {1'b0, rd_base} + {1'b0, rd_size};
  assign top_c   = top_sum[64] ? ALL_ONES : top_sum[63:0];
  assign tot_sum = {1'b0, total_r} + {1'b0, rd_size};

  // Status towards the controller.
  always_comb begin
    stat            = '0;
    stat.kind       = kind_r;
    stat.alloc_skip = fail_c || (count_r < CW'(2));
    stat.scan_done  = (ptr_r >= count_r) && !rd_vld_r;
    stat.find_done  = found_r || ((ptr_r == '0) && !rd_vld_r);
    stat.place_go   = found_r && room;
    stat.has_pad    = has_pad;
    stat.shift_done = (ptr_r <= CW'(j_r)) && !rd_vld_r;
  end

  // Operation decoder.
  always_comb begin
    kind_nxt    = kind_r;
    base_in_nxt = base_in_r;
    size_in_nxt = size_in_r;
    type_in_nxt = type_in_r;
    first_nxt   = first_r;
    bytes_nxt   = bytes_r;
    rfail_nxt   = rfail_r;
    need_nxt    = need_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = ptr_r[AW-1:0];
    found_nxt   = found_r;
    j_nxt       = j_r;
    fb_nxt      = fb_r;
    fs_nxt      = fs_r;
    wptr_nxt    = wptr_r;
    cur_nxt     = cur_r;
    rem_nxt     = rem_r;
    addr_nxt    = addr_r;
    status_nxt  = status_r;
    top_nxt     = top_r;
    total_nxt   = total_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    unique case (op)
      DP_CAPTURE: begin
        kind_nxt    = in_kind;
        base_in_nxt = in_region_base;
        size_in_nxt = in_region_size;
        type_in_nxt = in_region_type;
        first_nxt   = in_first_of_map;
        bytes_nxt   = rnd_sum[63:0] & ~gran_m1;
        rfail_nxt   = rnd_sum[64];
      end
      DP_PREP: begin
        addr_nxt   = '0;
        status_nxt = ST_OK;
        top_nxt    = '0;
        total_nxt  = '0;
        found_nxt  = 1'b0;
        need_nxt   = (kind_r == KIND_ALLOC_2M) ? need_sum[63:0] : bytes_r;
        ptr_nxt    = (kind_r == KIND_ALIGN) ? '0 : count_r - CW'(1);
        if (((kind_r == KIND_ALLOC_4K) || (kind_r == KIND_ALLOC_2M)) && stat.alloc_skip) begin
          status_nxt = ST_NOFIT;
        end
      end
      DP_LOAD: begin
        if (pos_c < DEPTH_C) begin
          ram_we    = 1'b1;
          ram_waddr = pos_c[AW-1:0];
          ram_wdata = {base_in_r, size_in_r & SIZE_MASK, type_in_r};
          count_nxt = pos_c + CW'(1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      DP_ALIGN: begin
        // Read ahead by one entry and write back the previous one.
        if (ptr_r < count_r) begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + CW'(1);
        end
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r;
          ram_wdata = align_entry(rd_data);
        end
      end
      DP_FIND: begin
        // Scan downwards, stopping at entry 1 or the first fit.
        if ((ptr_r != '0) && !found_r) begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r - CW'(1);
        end
        if (rd_vld_r && !found_r && (rd_type == TYPE_FREE) && (rd_size >= need_r)) begin
          found_nxt = 1'b1;
          j_nxt     = rd_idx_r;
          fb_nxt    = rd_base;
          fs_nxt    = rd_size;
        end
      end
      DP_PLACE: begin
        if (!found_r) begin
          status_nxt = ST_NOFIT;
        end else if (!room) begin
          status_nxt = ST_FULL;
        end else begin
          wptr_nxt = j_r;
          cur_nxt  = fb_r;
          rem_nxt  = fs_r;
          ptr_nxt  = count_r - CW'(1);
        end
      end
      DP_SHIFT: begin
        // Move the entries above the fit up by one or two places.
        if (ptr_r > CW'(j_r)) begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r - CW'(1);
        end
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r + AW'(d_c);
          ram_wdata = rd_data;
        end
      end
      DP_WPAD: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_r;
        ram_wdata = {cur_r, pad_c, TYPE_FREE};
        cur_nxt   = cur_r + pad_c;
        rem_nxt   = rem_r - pad_c;
        wptr_nxt  = wptr_r + AW'(1);
      end
      DP_WUSED: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_r;
        ram_wdata = {cur_r, bytes_r, TYPE_USED};
        addr_nxt  = cur_r;
        cur_nxt   = cur_r + bytes_r;
        rem_nxt   = rem_r - bytes_r;
        wptr_nxt  = wptr_r + AW'(1);
      end
      DP_WREST: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_r;
        ram_wdata = {cur_r, rem_r, TYPE_FREE};
        count_nxt = count_r + CW'(d_c);
      end
      DP_SUM_INIT: begin
        ptr_nxt = '0;
      end
      DP_SUM: begin
        if (ptr_r < count_r) begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + CW'(1);
        end
        if (rd_vld_r && (rd_type == TYPE_FREE)) begin
          if (top_c > top_r) begin
            top_nxt = top_c;
          end
          total_nxt = tot_sum[64] ? ALL_ONES : tot_sum[63:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    base_in_r <= base_in_nxt;
    size_in_r <= size_in_nxt;
    type_in_r <= type_in_nxt;
    first_r   <= first_nxt;
    bytes_r   <= bytes_nxt;
    rfail_r   <= rfail_nxt;
    need_r    <= need_nxt;
    ptr_r     <= ptr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    j_r       <= j_nxt;
    fb_r      <= fb_nxt;
    fs_r      <= fs_nxt;
    wptr_r    <= wptr_nxt;
    cur_r     <= cur_nxt;
    rem_r     <= rem_nxt;
    addr_r    <= addr_nxt;
    status_r  <= status_nxt;
    top_r     <= top_nxt;
    total_r   <= total_nxt;
  end

  assign out_alloc_address    = addr_r;
  assign out_status           = status_r;
  assign out_entry_count      = 7'(count_r);
  assign out_highest_free_top = top_r;
  assign out_total_free       = total_r;

endmodule

// File: rtl/core/memory_region_table_allocator_core.sv
// Top level of the memory region table allocator: controller, datapath and checks.
// A query or load walks the table once for its free summary; align adds an align sweep
// before it, and an allocation can add a fit search and an entry shift.
// Each sweep is bounded by the single read port of the region table memory,
// which every sweep (align, fit search, entry shift, free summary) walks one
// entry a cycle. A new request is taken the cycle after the result strobe.
// Synchronous reset empties the table; entry contents are left as they were.
`timescale 1ns / 1ps

module memory_region_table_allocator_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_region_base,
  input  logic [63:0] in_region_size,
  input  logic [3:0]  in_region_type,
  input  logic        in_first_of_map,
  input  logic [63:0] in_request_bytes,
  output logic        out_valid,
  output logic [63:0] out_alloc_address,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_count,
  output logic [63:0] out_highest_free_top,
  output logic [63:0] out_total_free
);

  import mrta_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  mrta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mrta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .op                   (op),
    .stat                 (stat),
    .in_kind              (in_kind),
    .in_region_base       (in_region_base),
    .in_region_size       (in_region_size),
    .in_region_type       (in_region_type),
    .in_first_of_map      (in_first_of_map),
    .in_request_bytes     (in_request_bytes),
    .out_alloc_address    (out_alloc_address),
    .out_status           (out_status),
    .out_entry_count      (out_entry_count),
    .out_highest_free_top (out_highest_free_top),
    .out_total_free       (out_total_free)
  );

  // An accepted request makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // After a result the block is idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after result");

  // A failed request never reports an allocated address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_alloc_address == 64'd0))
    else $error("address reported on failed request");

  // Table writes of new entries only happen while busy.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((op == DP_LOAD) || (op == DP_WREST)) |-> (busy && !out_valid))
    else $error("table update outside a request");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the memory region table allocator core.
`timescale 1ns / 1ps

module testbench;
  import mrta_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [2:0] KIND_QUERY = 3'd4;

  typedef struct packed {
    logic [63:0] alloc_address;
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [63:0] highest_free_top;
    logic [63:0] total_free;
  } region_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [63:0] in_region_base;
  logic [63:0] in_region_size;
  logic [3:0]  in_region_type;
  logic        in_first_of_map;
  logic [63:0] in_request_bytes;
  logic        out_valid;
  logic [63:0] out_alloc_address;
  logic [1:0]  out_status;
  logic [6:0]  out_entry_count;
  logic [63:0] out_highest_free_top;
  logic [63:0] out_total_free;

  // Shadow copy of the region table.
  logic [63:0] shadow_base [DEPTH];
  logic [63:0] shadow_size [DEPTH];
  logic [3:0]  shadow_type [DEPTH];
  int          shadow_count;

  region_result_t pending_results[$];
  bit  failed;
  bit  start_high;
  int  requests_sent;

  memory_region_table_allocator_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_region_base(in_region_base),
    .in_region_size(in_region_size), .in_region_type(in_region_type),
    .in_first_of_map(in_first_of_map), .in_request_bytes(in_request_bytes),
    .out_valid(out_valid), .out_alloc_address(out_alloc_address),
    .out_status(out_status), .out_entry_count(out_entry_count),
    .out_highest_free_top(out_highest_free_top), .out_total_free(out_total_free)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Move entries at and above pos up by one place.
  task automatic open_slot(input int pos);
    for (int k = shadow_count; k > pos; k--) begin
      shadow_base[k] = shadow_base[k-1];
      shadow_size[k] = shadow_size[k-1];
      shadow_type[k] = shadow_type[k-1];
    end
    shadow_count++;
  endtask

  // The front len bytes of entry pos take type t; the remainder stays free.
  task automatic carve_front(input int pos, input logic [63:0] len, input logic [3:0] t);
    logic [63:0] b;
    logic [63:0] s;
    b = shadow_base[pos];
    s = shadow_size[pos];
    open_slot(pos);
    shadow_base[pos]   = b;
    shadow_size[pos]   = len;
    shadow_type[pos]   = t;
    shadow_base[pos+1] = b + len;
    shadow_size[pos+1] = s - len;
    shadow_type[pos+1] = TYPE_FREE;
  endtask

  // Highest index from 1 upwards of a free region of at least need bytes, else 0.
  function automatic int find_free_fit(input logic [63:0] need);
    for (int i = shadow_count - 1; i >= 1; i--)
      if (shadow_type[i] == TYPE_FREE && shadow_size[i] >= need) return i;
    return 0;
  endfunction

  // Apply one request to the shadow table and work out its result.
  task automatic predict_region_result(input logic [2:0] kind, input logic [63:0] base,
                                       input logic [63:0] size, input logic [3:0] rtype,
                                       input logic first, input logic [63:0] req,
                                       output region_result_t res);
    logic [63:0] rem;
    logic [63:0] bytes;
    logic [63:0] pad;
    logic [63:0] t;
    bit ok;
    int j;
    res = '0;
    res.status = ST_OK;
    ok = 1;
    bytes = req;
    case (kind)
      KIND_LOAD: begin
        if (first) shadow_count = 0;
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_base[shadow_count] = base;
          shadow_size[shadow_count] = size & SIZE_MASK;
          shadow_type[shadow_count] = rtype;
          shadow_count++;
        end
      end
      KIND_ALIGN: begin
        for (int i = 0; i < shadow_count; i++) begin
          rem = shadow_base[i] & (GRAN_4K - 1);
          if (rem != 0) begin
            shadow_base[i] = shadow_base[i] + (GRAN_4K - rem);
            shadow_size[i] = (shadow_size[i] >= GRAN_4K - rem) ?
                             shadow_size[i] - (GRAN_4K - rem) : 64'd0;
          end
          shadow_size[i] = shadow_size[i] & ~(GRAN_4K - 1);
        end
      end
      KIND_ALLOC_4K: begin
        rem = req & (GRAN_4K - 1);
        if (rem != 0) begin
          if (req > ALL_ONES - (GRAN_4K - rem)) ok = 0;
          else bytes = req + (GRAN_4K - rem);
        end
        j = ok ? find_free_fit(bytes) : 0;
        if (j == 0) begin
          res.status = ST_NOFIT;
        end else if (shadow_count + 1 > DEPTH) begin
          res.status = ST_FULL;
        end else begin
          res.alloc_address = shadow_base[j];
          carve_front(j, bytes, TYPE_USED);
        end
      end
      KIND_ALLOC_2M: begin
        rem = req & (GRAN_2M - 1);
        if (rem != 0) begin
          if (req > ALL_ONES - (GRAN_2M - rem)) ok = 0;
          else bytes = req + (GRAN_2M - rem);
        end
        if (ok && bytes > ALL_ONES - GRAN_2M) ok = 0;
        j = ok ? find_free_fit(bytes + GRAN_2M) : 0;
        if (j == 0) begin
          res.status = ST_NOFIT;
        end else begin
          rem = shadow_base[j] & (GRAN_2M - 1);
          pad = (rem != 0) ? GRAN_2M - rem : 64'd0;
          if (shadow_count + ((pad != 0) ? 2 : 1) > DEPTH) begin
            res.status = ST_FULL;
          end else begin
            if (pad != 0) begin
              carve_front(j, pad, TYPE_FREE);
              j++;
            end
            res.alloc_address = shadow_base[j];
            carve_front(j, bytes, TYPE_USED);
          end
        end
      end
      default: ;
    endcase
    // Free summary with saturation.
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_type[i] == TYPE_FREE) begin
        t = (shadow_base[i] > ALL_ONES - shadow_size[i]) ? ALL_ONES :
            shadow_base[i] + shadow_size[i];
        if (t > res.highest_free_top) res.highest_free_top = t;
        res.total_free = (res.total_free > ALL_ONES - shadow_size[i]) ? ALL_ONES :
                         res.total_free + shadow_size[i];
      end
    end
    res.entry_count = shadow_count[6:0];
  endtask

  // Send one request, wait for it to be taken, then leave a random gap.
  task automatic send_request(input logic [2:0] kind, input logic [63:0] base,
                              input logic [63:0] size, input logic [3:0] rtype,
                              input logic first, input logic [63:0] req);
    region_result_t res;
    int r;
    int gap;
    in_kind          <= kind;
    in_region_base   <= base;
    in_region_size   <= size;
    in_region_type   <= rtype;
    in_first_of_map  <= first;
    in_request_bytes <= req;
    if (!start_high) start <= 1'b1;
    start_high = 1;
    do @(posedge clk); while (busy);
    predict_region_result(kind, base, size, rtype, first, req, res);
    pending_results.push_back(res);
    requests_sent++;
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      start_high = 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Compare each result strobe with the oldest expectation.
  always @(posedge clk) begin
    region_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result with no request outstanding");
        failed = 1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_alloc_address !== exp_res.alloc_address) begin
          $error("alloc_address expected %h actual %h", exp_res.alloc_address,
                 out_alloc_address);
          failed = 1;
        end
        if (out_status !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, out_status);
          failed = 1;
        end
        if (out_entry_count !== exp_res.entry_count) begin
          $error("entry_count expected %0d actual %0d", exp_res.entry_count,
                 out_entry_count);
          failed = 1;
        end
        if (out_highest_free_top !== exp_res.highest_free_top) begin
          $error("highest_free_top expected %h actual %h", exp_res.highest_free_top,
                 out_highest_free_top);
          failed = 1;
        end
        if (out_total_free !== exp_res.total_free) begin
          $error("total_free expected %h actual %h", exp_res.total_free, out_total_free);
          failed = 1;
        end
      end
    end
  end

  // Queries, a load, allocations and unknown kinds on an empty or single-entry table.
  task automatic test_small_table();
    send_request(KIND_QUERY, '0, '0, '0, 1'b0, '0);
    send_request(KIND_ALLOC_4K, '0, '0, '0, 1'b0, 64'h1000);
    send_request(KIND_LOAD, 64'h10_0000, 64'h100_000F, TYPE_FREE, 1'b1, '0);
    send_request(KIND_ALLOC_4K, '0, '0, '0, 1'b0, 64'h10);
    send_request(3'd5, ALL_ONES, ALL_ONES, 4'hF, 1'b1, ALL_ONES);
    send_request(3'd7, '0, '0, '0, 1'b0, '0);
  endtask

  // Extreme loads, then align with wrapping bases and clamped sizes.
  task automatic test_load_and_align();
    send_request(KIND_LOAD, ALL_ONES, ALL_ONES, 4'hF, 1'b1, ALL_ONES);
    send_request(KIND_LOAD, 64'hFFFF_FFFF_FFFF_F001, 64'h2000, TYPE_FREE, 1'b0, '0);
    send_request(KIND_LOAD, 64'h0000_0000_0000_0FFF, 64'h10, TYPE_FREE, 1'b0, '0);
    send_request(KIND_LOAD, ALL_ONES - 64'hFFF, ALL_ONES, TYPE_FREE, 1'b0, '0);
    send_request(KIND_LOAD, 64'h8000_0000, ALL_ONES, TYPE_FREE, 1'b0, '0);
    send_request(KIND_LOAD, 64'h123, 64'h3456_7890, 4'd2, 1'b0, '0);
    send_request(KIND_ALIGN, '0, '0, '0, 1'b0, '0);
  endtask

  // Allocation corners: zero request, rounding overflow, 2 MiB with and without pad.
  task automatic test_alloc_corners();
    send_request(KIND_LOAD, 64'h0, 64'h1000, 4'd3, 1'b1, '0);
    send_request(KIND_LOAD, 64'h12_3000, 64'h4000_0000, TYPE_FREE, 1'b0, '0);
    send_request(KIND_LOAD, 64'h8000_0000, 64'h80_0000, TYPE_FREE, 1'b0, '0);
    send_request(KIND_ALLOC_4K, '0, '0, '0, 1'b0, 64'h0);
    send_request(KIND_ALLOC_4K, '0, '0, '0, 1'b0, ALL_ONES);
    send_request(KIND_ALLOC_2M, '0, '0, '0, 1'b0, ALL_ONES - 64'h10_0000);
    send_request(KIND_ALLOC_2M, '0, '0, '0, 1'b0, 64'h0);
    send_request(KIND_ALLOC_2M, '0, '0, '0, 1'b0, 64'h30_0001);
    send_request(KIND_ALLOC_2M, '0, '0, '0, 1'b0, 64'h1000_0000);
    send_request(KIND_ALLOC_4K, '0, '0, '0, 1'b0, 64'h8000_0000);
  endtask

  // Random maps followed by allocations, with some noise and full tables.
  task automatic test_random_maps();
    int n;
    int r;
    logic [63:0] addr;
    while (requests_sent < 1200) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // Noise request with every field random.
        send_request(3'($urandom_range(0, 7)), rand64(), rand64(),
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), rand64());
      end else begin
        n = (r < 15) ? $urandom_range(62, 66) : $urandom_range(1, 8);
        addr = {24'd0, 8'($urandom_range(0, 255)), 32'd0} |
               ({32'd0, $urandom()} & 64'hFFFF_F0F7);
        for (int i = 0; i < n; i++) begin
          logic [63:0] sz;
          sz = {40'd0, 24'($urandom_range(0, 24'hFF_FFFF))} << $urandom_range(0, 8);
          send_request(KIND_LOAD, addr, sz,
                       ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : TYPE_FREE,
                       (i == 0), '0);
          addr = addr + sz + {52'd0, 12'($urandom())};
        end
        if ($urandom_range(0, 1)) send_request(KIND_ALIGN, '0, '0, '0, 1'b0, '0);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_request($urandom_range(0, 1) ? KIND_ALLOC_4K : KIND_ALLOC_2M, rand64(),
                       rand64(), 4'($urandom_range(0, 15)), 1'b0,
                       {40'd0, 24'($urandom_range(0, 24'hFF_FFFF))} >>
                       $urandom_range(0, 12));
        send_request(KIND_QUERY, '0, '0, '0, 1'b0, '0);
      end
    end
  endtask

  // Main sequence.
  initial begin
    failed = 0;
    start_high = 0;
    requests_sent = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= '0;
    in_region_base <= '0;
    in_region_size <= '0;
    in_region_type <= '0;
    in_first_of_map <= 1'b0;
    in_request_bytes <= '0;
    shadow_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_table();
    test_load_and_align();
    test_alloc_corners();
    test_random_maps();
    if (start_high) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule
